>>> hdl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg: shared types, constants and ROM builder
// Field widths, config register indexes, divider payload structs and the
// critical-bandwidth function used to fill the bandwidth ROM at elaboration.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam int ROM_DEPTH_DEFAULT = 256;
  localparam int MAX_BINS          = 4096;
  localparam int ROM_SPAN_HZ       = 32768;

  localparam int CBW_W  = 18;
  localparam int NUM_W  = CBW_W + 7;
  localparam int DEN_W  = 28;
  localparam int QBITS  = 12;

  localparam logic signed [15:0] FLOOR_DB = -16'sd20480;
  localparam logic [11:0] Q_BASE = 12'd256;
  localparam logic [11:0] Q_MAX  = 12'd2560;

  typedef enum logic [2:0] {
    CFG_ENABLED     = 3'd0,
    CFG_SENSITIVITY = 3'd1,
    CFG_OFFSET      = 3'd2,
    CFG_MIN_MASKING = 3'd3,
    CFG_BIN_WIDTH   = 3'd4,
    CFG_NUM_BINS    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [19:0] freq;
    logic [15:0] gain;
    logic [8:0]  conf;
  } side_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    side_t            side;
  } div_in_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 64'd0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // critical bandwidth in 1/16 Hz at f = k * step Hz
  function automatic logic [63:0] cbw_entry(input logic [63:0] k, input logic [63:0] step);
    logic [63:0] f;
    logic [63:0] y;
    logic [63:0] x;
    logic [63:0] frac;
    logic [63:0] l;
    logic [63:0] e;
    logic [63:0] ip;
    logic [63:0] fr;
    logic [63:0] p;
    logic [63:0] r;
    int hb;
    f = k * step;
    y = 64'd65536 + (64'd458752 * f * f) / 64'd5000000;
    hb = 0;
    frac = 64'd0;
    while (hb < 62 && (y >> (hb + 1)) != 64'd0) hb = hb + 1;
    x = (hb <= 30) ? (y << (30 - hb)) : (y >> (hb - 30));
    for (int i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | (64'd1 << i);
      end
    end
    l = (64'(hb - 16) << 16) | frac;
    e = l * 64'd69 / 64'd100;
    ip = (e >> 16) & 64'd15;
    fr = e & 64'hFFFF;
    p = 64'd1 << 30;
    r = isqrt64(64'd1 << 61);
    for (int i = 15; i >= 0; i--) begin
      if (fr[i]) p = (p * r) >> 30;
      r = isqrt64(r << 30);
    end
    return 64'd400 + (((64'd1200 * p) << ip) >> 30);
  endfunction

endpackage

>>> hdl/smd_cbw_rom.sv
// ----------------------------------------------------------------------------
// smd_cbw_rom: critical-bandwidth ROM
// Constant table filled at elaboration, registered read with enable.
// ----------------------------------------------------------------------------
module smd_cbw_rom #(
  parameter int DEPTH = smd_pkg::ROM_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  output logic [smd_pkg::CBW_W-1:0]  data
);

  localparam int STEP_RAW = smd_pkg::ROM_SPAN_HZ / DEPTH;
  localparam int STEP     = (STEP_RAW == 0) ? 1 : STEP_RAW;

  logic [smd_pkg::CBW_W-1:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    localparam logic [63:0] VAL = smd_pkg::cbw_entry(64'(k), 64'(STEP));
    assign rom[k] = VAL[smd_pkg::CBW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

>>> hdl/smd_qdiv.sv
// ----------------------------------------------------------------------------
// smd_qdiv: pipelined filter-Q divider
// Restoring division, one quotient bit per stage, saturating at 4096;
// output stage adds the Q base and clamps. Sideband rides along.
// ----------------------------------------------------------------------------
module smd_qdiv (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  smd_pkg::div_in_t din,
  output logic             out_valid,
  output logic [11:0]      out_q,
  output smd_pkg::side_t   out_side
);

  localparam int NUM_W = smd_pkg::NUM_W;
  localparam int DEN_W = smd_pkg::DEN_W;
  localparam int QBITS = smd_pkg::QBITS;
  localparam int CMP_W = DEN_W + QBITS;

  typedef struct packed {
    logic             valid;
    logic             sat;
    logic [NUM_W-1:0] rem;
    logic [QBITS-1:0] quo;
    logic [DEN_W-1:0] den;
    smd_pkg::side_t   side;
  } div_stage_t;

  div_stage_t st [QBITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid <= din.valid;
      st[0].sat   <= CMP_W'(din.num) >= {din.den, QBITS'(0)};
      st[0].rem   <= din.num;
      st[0].quo   <= '0;
      st[0].den   <= din.den;
      st[0].side  <= din.side;
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_bit
    localparam int B = QBITS - k;
    logic [CMP_W-1:0] shifted;
    logic             take;
    logic [CMP_W-1:0] diff;

    assign shifted = CMP_W'(st[k-1].den) << B;
    assign take    = !st[k-1].sat && (CMP_W'(st[k-1].rem) >= shifted);
    assign diff    = CMP_W'(st[k-1].rem) - shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else if (en) begin
        st[k].valid  <= st[k-1].valid;
        st[k].sat    <= st[k-1].sat;
        st[k].rem    <= take ? diff[NUM_W-1:0] : st[k-1].rem;
        st[k].quo    <= st[k-1].quo | (take ? (QBITS'(1) << B) : QBITS'(0));
        st[k].den    <= st[k-1].den;
        st[k].side   <= st[k-1].side;
      end
    end
  end

  logic [QBITS:0] qsum;
  logic [11:0]    q_next;

  assign qsum   = (QBITS + 1)'(smd_pkg::Q_BASE) + (QBITS + 1)'(st[QBITS].quo);
  assign q_next = (st[QBITS].sat || qsum > (QBITS + 1)'(smd_pkg::Q_MAX)) ?
                  smd_pkg::Q_MAX : qsum[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st[QBITS].valid;
      out_q     <= q_next;
      out_side  <= st[QBITS].side;
    end
  end

endmodule

>>> hdl/spectral_masking_detector_top.sv
// ----------------------------------------------------------------------------
// spectral_masking_detector_top: per-bin cross-track masking detector
// Pipeline: 4 filter/arithmetic stages, then 14 divider stages incl. output.
// Throughput: one bin per cycle; the whole pipeline advances together and
//   holds while the output register is full and not taken.
// Reset: config registers return to their defaults, all stage valids clear.
// ----------------------------------------------------------------------------
module spectral_masking_detector_top #(
  parameter int BANDWIDTH_ROM_DEPTH = smd_pkg::ROM_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         pair_tag,
  input  logic [11:0]        bin_index,
  input  logic signed [15:0] masker_db,
  input  logic signed [15:0] masked_db,
  input  logic signed [15:0] masker_rms,
  input  logic signed [15:0] masked_rms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         tag_out,
  output logic [19:0]        frequency,
  output logic [15:0]        boost_gain,
  output logic [11:0]        filter_q,
  output logic [8:0]         confidence
);

  localparam int ROM_STEP_RAW = smd_pkg::ROM_SPAN_HZ / BANDWIDTH_ROM_DEPTH;
  localparam int ROM_STEP     = (ROM_STEP_RAW == 0) ? 1 : ROM_STEP_RAW;
  localparam int IDX_DIV      = 16 * ROM_STEP;
  localparam int IDX_LIMIT    = IDX_DIV * (BANDWIDTH_ROM_DEPTH - 1);
  localparam int IDX_W        = $clog2(BANDWIDTH_ROM_DEPTH);
  localparam int RECIP_SHIFT  = 34;
  localparam logic [27:0] IDX_RECIP =
    28'(((64'd1 << RECIP_SHIFT) + 64'(IDX_DIV) - 64'd1) / 64'(IDX_DIV));

  // config registers
  logic               enabled;
  logic [11:0]        sensitivity;
  logic signed [15:0] threshold_offset;
  logic [14:0]        min_masking;
  logic [15:0]        bin_width;
  logic [12:0]        num_bins;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled          <= 1'b1;
      sensitivity      <= 12'd256;
      threshold_offset <= 16'sd0;
      min_masking      <= 15'd768;
      bin_width        <= 16'd188;
      num_bins         <= 13'd2048;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        smd_pkg::CFG_ENABLED:     enabled          <= cfg_data[0];
        smd_pkg::CFG_SENSITIVITY: sensitivity      <= cfg_data[11:0];
        smd_pkg::CFG_OFFSET:      threshold_offset <= cfg_data;
        smd_pkg::CFG_MIN_MASKING: min_masking      <= cfg_data[14:0];
        smd_pkg::CFG_BIN_WIDTH:   bin_width        <= cfg_data;
        smd_pkg::CFG_NUM_BINS:    num_bins         <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: gating checks, masking amount, frequency
  logic [16:0]        nb;
  logic               s1_valid_next;
  logic signed [17:0] amt_in;
  logic signed [16:0] diff_in;

  assign nb = ({4'b0, num_bins} < 17'(smd_pkg::MAX_BINS)) ?
              {4'b0, num_bins} : 17'(smd_pkg::MAX_BINS);
  assign amt_in  = 18'(masker_db) - 18'(threshold_offset) - 18'(masked_db);
  assign diff_in = 17'(masker_rms) - 17'(masked_rms);
  assign s1_valid_next = in_valid && enabled && (masker_rms > masked_rms) &&
                         (bin_index != 12'd0) &&
                         ({5'b0, bin_index} + 17'd2 <= nb) &&
                         (masker_db >= smd_pkg::FLOOR_DB) &&
                         (masked_db >= smd_pkg::FLOOR_DB);

  logic               s1_valid;
  logic [7:0]         s1_tag;
  logic signed [17:0] s1_amt;
  logic [15:0]        s1_diff;
  logic [27:0]        s1_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag  <= pair_tag;
      s1_amt  <= amt_in;
      s1_diff <= diff_in[15:0];
      s1_freq <= {16'b0, bin_index} * {12'b0, bin_width};
    end
  end

  // stage 2: amount filter, norm/20, gain pre-clamp, confidence product, ROM index
  logic [16:0] amt_u;
  logic        amt_ok;
  logic [24:0] nprod;
  logic [16:0] gsum;
  logic [46:0] iprod;
  logic        xbig;

  assign amt_u  = s1_amt[16:0];
  assign amt_ok = (s1_amt > 18'sd0) && (amt_u >= {2'b0, min_masking});
  assign nprod  = {12'b0, amt_u[12:0]} * 25'd3277;
  assign gsum   = amt_u + 17'd768;
  assign xbig   = s1_freq >= 28'(IDX_LIMIT);
  assign iprod  = 47'(s1_freq[18:0]) * 47'(IDX_RECIP);

  logic             s2_valid;
  logic [7:0]       s2_tag;
  logic [27:0]      s2_freq;
  logic             s2_nbig;
  logic [7:0]       s2_nmul;
  logic [11:0]      s2_gpre;
  logic [32:0]      s2_cprod;
  logic [IDX_W-1:0] s2_ridx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && amt_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag   <= s1_tag;
      s2_freq  <= s1_freq;
      s2_nbig  <= amt_u >= 17'd5120;
      s2_nmul  <= nprod[23:16];
      s2_gpre  <= (gsum > 17'd3072) ? 12'd3072 : gsum[11:0];
      s2_cprod <= 33'(s1_diff) * 33'(amt_u);
      s2_ridx  <= xbig ? IDX_W'(BANDWIDTH_ROM_DEPTH - 1) : iprod[RECIP_SHIFT +: IDX_W];
    end
  end

  // stage 3: norm filter, gain, confidence; ROM read
  logic [8:0]  norm;
  logic [23:0] gprod;
  logic [24:0] cmul;

  assign norm  = s2_nbig ? 9'd256 : {1'b0, s2_nmul};
  assign gprod = 24'(s2_gpre) * 24'(sensitivity);
  assign cmul  = 25'(s2_cprod[19:9]) * 25'd3277;

  logic                      s3_valid;
  logic [7:0]                s3_tag;
  logic [27:0]               s3_freq;
  logic [8:0]                s3_norm;
  logic [15:0]               s3_gain;
  logic [8:0]                s3_conf;
  logic [smd_pkg::CBW_W-1:0] s3_cbw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid && ({6'b0, norm} >= min_masking);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tag  <= s2_tag;
      s3_freq <= s2_freq;
      s3_norm <= norm;
      s3_gain <= gprod[23:8];
      s3_conf <= (s2_cprod >= 33'd655360) ? 9'd256 : {1'b0, cmul[21:14]};
    end
  end

  smd_cbw_rom #(
    .DEPTH (BANDWIDTH_ROM_DEPTH)
  ) u_rom (
    .clk  (clk),
    .en   (adv),
    .addr (s2_ridx),
    .data (s3_cbw)
  );

  // stage 4: sensitivity filter, frequency saturation, divider operands
  logic [20:0]      nsens;
  smd_pkg::div_in_t s4;
  smd_pkg::div_in_t s4_next;

  assign nsens = 21'(s3_norm) * 21'(sensitivity);

  always_comb begin
    s4_next.valid     = s3_valid && ({2'b0, nsens} >= {min_masking, 8'b0});
    s4_next.num       = {s3_cbw, 7'b0};
    s4_next.den       = s3_freq;
    s4_next.side.tag  = s3_tag;
    s4_next.side.freq = (s3_freq > 28'd1048575) ? 20'hFFFFF : s3_freq[19:0];
    s4_next.side.gain = s3_gain;
    s4_next.side.conf = s3_conf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else if (adv) begin
      s4 <= s4_next;
    end
  end

  smd_pkg::side_t out_side;

  smd_qdiv u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .din       (s4),
    .out_valid (out_valid),
    .out_q     (filter_q),
    .out_side  (out_side)
  );

  assign tag_out    = out_side.tag;
  assign frequency  = out_side.freq;
  assign boost_gain = out_side.gain;
  assign confidence = out_side.conf;

  a_q_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (filter_q >= smd_pkg::Q_BASE && filter_q <= smd_pkg::Q_MAX))
    else $error("filter_q out of range");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (confidence <= 9'd256 && boost_gain <= 16'd49152))
    else $error("gain or confidence out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s1_valid) && $stable(s3_valid) && $stable(s4.valid)))
    else $error("pipeline moved during stall");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_norm <= 9'd256))
    else $error("normalized masking out of range");

endmodule
